@@ hw/rtl/tqrr_pkg.sv @@
package tqrr_pkg;

  localparam int LANES       = 3;
  localparam int QUEUE_DEPTH = 16;
  localparam int VALUE_W     = 31;
  localparam int LANE_W      = 2;
  localparam int BURST_W     = 2;
  localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W      = $clog2(LANES * QUEUE_DEPTH);

  localparam logic [BURST_W-1:0] BURST_RESET = BURST_W'(3);

  localparam logic ACT_ENQUEUE = 1'b0;
  localparam logic ACT_ROUND   = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACCEPTED = 2'd0,
    KIND_REFUSED  = 2'd1,
    KIND_SERVED   = 2'd2,
    KIND_EMPTY    = 2'd3
  } kind_t;

  typedef struct packed {
    logic               action;
    logic [LANE_W-1:0]  lane;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [VALUE_W-1:0] out_value;
    logic [LANE_W-1:0]  source_lane;
    logic               last;
  } result_t;

  // classified command passed from front to back
  typedef struct packed {
    logic               is_round;
    logic               lane_ok;
    logic [LANE_W-1:0]  lane;
    logic [VALUE_W-1:0] value;
  } op_t;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx);
    next_idx = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
  endfunction

endpackage

@@ hw/rtl/three_queue_burst_round_robin_core.sv @@
// Three-lane FIFO store with a burst round-robin drain.
// Commands: drive cmd and raise start; the command is taken at an edge where
// start is high and busy is low. cmd.action selects enqueue (value into
// cmd.lane) or one service round over lanes 0, 1, 2, up to burst_size items
// per lane; a burst_size of zero acts as one.
// Results: each item appears on result for one cycle with result_valid high.
// The receiver cannot stall, so results are never held back.
// Enqueue: one result (accepted or refused), registered once the command has
// left the command queue. Round: the back end enters its round state, then
// serves one item per cycle, but each move to the next lane holds the stream;
// an all-empty round gives one nothing-to-serve result instead. The last
// result of each command has last set.
// The pace is set by the single-port lane store in the back end: one read or
// one write per cycle, so enqueues stream at one per cycle outside a round.
// A two-entry command queue sits in front; busy rises when that queue is full.
// Config: cfg_data (burst_size) is always ready; write it only when idle.
// Reset: all lanes empty, burst_size = 3, queue empty, no result pending.
module three_queue_burst_round_robin_core
  import tqrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  cmd_t               cmd,
  output logic               busy,
  output logic               result_valid,
  output result_t            result,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BURST_W-1:0] cfg_data
);

  logic [BURST_W-1:0] burst_size;
  logic               op_valid;
  op_t                op;
  logic               op_pop;

  // burst register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_size <= BURST_RESET;
    end else if (cfg_valid && cfg_ready) begin
      burst_size <= cfg_data;
    end
  end

  // front: take and classify commands into the queue
  tqrr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .busy     (busy),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  // back: lane store, enqueue and round execution
  tqrr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .burst_size   (burst_size),
    .op_valid     (op_valid),
    .op           (op),
    .op_pop       (op_pop),
    .result_valid (result_valid),
    .result       (result)
  );

`ifndef ASSERT_OFF
  // only served items carry a value or a lane
  a_non_served_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_SERVED |->
      result.out_value == '0 && result.source_lane == '0)
    else $error("non-served result carries payload");

  // single-result kinds always close their command
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.kind != KIND_SERVED |-> result.last)
    else $error("single result without last");

  // queue pop only when something is queued
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    op_pop |-> op_valid)
    else $error("pop from empty command queue");

  // reset leaves nothing pending
  a_reset_clean: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("state not clean after reset");
`endif

endmodule

@@ hw/rtl/tqrr_front.sv @@
module tqrr_front
  import tqrr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic op_valid,
  output op_t  op,
  input  logic op_pop
);

  // two-entry command queue
  op_t        slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  op_t        op_in;

  assign busy     = (fill == 2'd2);
  assign push     = start && !busy;
  assign op_valid = (fill != 2'd0);
  assign op       = slots[rd_ptr];

  always_comb begin
    op_in.is_round = (cmd.action == ACT_ROUND);
    op_in.lane_ok  = (cmd.lane < LANE_W'(LANES));
    op_in.lane     = cmd.lane;
    op_in.value    = cmd.value;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (op_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, op_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ hw/rtl/tqrr_back.sv @@
module tqrr_back
  import tqrr_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic [BURST_W-1:0] burst_size,
  input  logic               op_valid,
  input  op_t                op,
  output logic               op_pop,
  output logic               result_valid,
  output result_t            result
);

  typedef enum logic {
    S_IDLE,
    S_ROUND
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   head  [LANES];
  logic [IDX_W-1:0]   tail  [LANES];
  logic [CNT_W-1:0]   count [LANES];
  logic [LANE_W-1:0]  cur_lane;
  logic [BURST_W-1:0] taken;
  logic [BURST_W-1:0] burst;

  logic [VALUE_W-1:0] mem [LANES*QUEUE_DEPTH];
  logic [VALUE_W-1:0] mem_q;

  // result stage
  logic               pend_valid;
  kind_t              pend_kind;
  logic [LANE_W-1:0]  pend_lane;
  logic               pend_last;

  logic [LANE_W-1:0]  sel_lane;
  logic               all_empty;
  logic               later_busy;
  logic               can_take;
  logic               last_take;
  logic               enq_ok;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  waddr;
  logic [ADDR_W-1:0]  raddr;
  logic [BURST_W-1:0] burst_eff;

  assign sel_lane  = (state == S_ROUND) ? cur_lane : (op.lane_ok ? op.lane : '0);
  assign burst_eff = (burst_size == '0) ? BURST_W'(1) : burst_size;
  assign op_pop    = (state == S_IDLE) && op_valid;

  always_comb begin
    all_empty  = 1'b1;
    later_busy = 1'b0;
    for (int l = 0; l < LANES; l++) begin
      if (count[l] != '0) begin
        all_empty = 1'b0;
        if (LANE_W'(l) > cur_lane) begin
          later_busy = 1'b1;
        end
      end
    end
  end

  assign can_take  = (state == S_ROUND) && (count[sel_lane] != '0) && (taken < burst);
  assign last_take = !later_busy &&
                     ((count[sel_lane] == CNT_W'(1)) ||
                      (({1'b0, taken} + (BURST_W+1)'(1)) >= {1'b0, burst}));
  assign enq_ok    = op.lane_ok && (count[sel_lane] != CNT_W'(QUEUE_DEPTH));
  assign mem_we    = op_pop && !op.is_round && enq_ok;
  assign mem_re    = can_take;
  assign waddr     = ADDR_W'(sel_lane) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail[sel_lane]);
  assign raddr     = ADDR_W'(sel_lane) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[sel_lane]);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= op.value;
    end
    if (mem_re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      pend_valid <= 1'b0;
      cur_lane   <= '0;
      taken      <= '0;
      for (int l = 0; l < LANES; l++) begin
        head[l]  <= '0;
        tail[l]  <= '0;
        count[l] <= '0;
      end
    end else begin
      pend_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (op_valid) begin
            pend_valid <= 1'b1;
            pend_lane  <= '0;
            pend_last  <= 1'b1;
            if (!op.is_round) begin
              if (enq_ok) begin
                tail[sel_lane]  <= next_idx(tail[sel_lane]);
                count[sel_lane] <= count[sel_lane] + CNT_W'(1);
                pend_kind       <= KIND_ACCEPTED;
              end else begin
                pend_kind <= KIND_REFUSED;
              end
            end else if (all_empty) begin
              pend_kind <= KIND_EMPTY;
            end else begin
              pend_valid <= 1'b0;
              state      <= S_ROUND;
              cur_lane   <= '0;
              taken      <= '0;
              burst      <= burst_eff;
            end
          end
        end
        S_ROUND: begin
          if (can_take) begin
            head[sel_lane]  <= next_idx(head[sel_lane]);
            count[sel_lane] <= count[sel_lane] - CNT_W'(1);
            taken           <= taken + BURST_W'(1);
            pend_valid      <= 1'b1;
            pend_kind       <= KIND_SERVED;
            pend_lane       <= cur_lane;
            pend_last       <= last_take;
            if (last_take) begin
              state <= S_IDLE;
            end
          end else begin
            cur_lane <= cur_lane + LANE_W'(1);
            taken    <= '0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_valid       = pend_valid;
  assign result.kind        = pend_kind;
  assign result.out_value   = (pend_kind == KIND_SERVED) ? mem_q : '0;
  assign result.source_lane = pend_lane;
  assign result.last        = pend_last;

endmodule
